@@ rtl/core/lad_pkg.sv @@
package lad_pkg;

    localparam int unsigned FIELD_W = 16;
    localparam int unsigned CFG_W   = 8;
    localparam int unsigned QUOT_W  = FIELD_W + 8;
    localparam int unsigned CNT_W   = $clog2(QUOT_W);
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // Target ratios in 8.8 fixed point.
    localparam logic [FIELD_W-1:0] RATIO_CLASS0 = 16'd455;
    localparam logic [FIELD_W-1:0] RATIO_CLASS1 = 16'd614;
    localparam logic [FIELD_W-1:0] RATIO_CLASS2 = 16'd340;

    localparam logic [1:0] CLASS_WIDE   = 2'd0;
    localparam logic [1:0] CLASS_SCOPE  = 2'd1;
    localparam logic [1:0] CLASS_NARROW = 2'd2;
    localparam logic [1:0] NO_CLASS     = 2'd3;

    localparam logic [FIELD_W-1:0] HELD_SIZE_RESET = 16'hffff;

    localparam logic [CFG_W-1:0] RES_TOL_RESET      = 8'd8;
    localparam logic [CFG_W-1:0] BAR_GUARD_RESET    = 8'd4;
    localparam logic [CFG_W-1:0] FULL_LIMIT_RESET   = 8'd10;
    localparam logic [CFG_W-1:0] CENTER_TOL_RESET   = 8'd20;
    localparam logic [CFG_W-1:0] RATIO_TOL_RESET    = 8'(16'h100 / 10);

    // Register indexes (byte address divided by four).
    localparam logic [2:0] REG_RES_TOL    = 3'd0;
    localparam logic [2:0] REG_BAR_GUARD  = 3'd1;
    localparam logic [2:0] REG_FULL_LIMIT = 3'd2;
    localparam logic [2:0] REG_CENTER_TOL = 3'd3;
    localparam logic [2:0] REG_RATIO_TOL  = 3'd4;

    typedef struct packed {
        logic [FIELD_W-1:0] total_width;
        logic [FIELD_W-1:0] left_bar;
        logic [FIELD_W-1:0] right_bar;
        logic [FIELD_W-1:0] total_height;
        logic [FIELD_W-1:0] top_bar;
        logic [FIELD_W-1:0] bottom_bar;
    } in_word_t;

    typedef struct packed {
        logic               format_changed;
        logic [FIELD_W-1:0] locked_width;
        logic [FIELD_W-1:0] locked_height;
        logic [1:0]         aspect_class;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] res_tolerance;
        logic [CFG_W-1:0] bar_guard;
        logic [CFG_W-1:0] fullscreen_limit;
        logic [CFG_W-1:0] centered_tolerance;
        logic [CFG_W-1:0] ratio_tolerance;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

    function automatic logic [FIELD_W-1:0] sub_sat(
        input logic [FIELD_W-1:0] a,
        input logic [CFG_W-1:0]   b
    );
        logic [FIELD_W-1:0] bx;
        bx = FIELD_W'(b);
        return (a > bx) ? (a - bx) : '0;
    endfunction

endpackage

@@ rtl/core/lad_div.sv @@
module lad_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lad_pkg::QUOT_W-1:0]   dividend,
    input  logic [lad_pkg::FIELD_W-1:0]  divisor,
    output logic                         busy,
    output logic                         done,
    output logic [lad_pkg::QUOT_W-1:0]   quotient
);

    // Restoring divider, one quotient bit per cycle.
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lad_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [lad_pkg::FIELD_W-1:0]   rem_reg, rem_next;
    logic [lad_pkg::QUOT_W-1:0]    dq_reg, dq_next;
    logic [lad_pkg::FIELD_W-1:0]   den_reg, den_next;
    logic [lad_pkg::FIELD_W:0]     shifted;
    logic [lad_pkg::FIELD_W:0]     diff;
    logic                          ge;

    always_comb
    begin
        shifted   = {rem_reg, dq_reg[lad_pkg::QUOT_W-1]};
        diff      = shifted - {1'b0, den_reg};
        ge        = (shifted >= {1'b0, den_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[lad_pkg::FIELD_W-1:0] : shifted[lad_pkg::FIELD_W-1:0];
            dq_next  = {dq_reg[lad_pkg::QUOT_W-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == lad_pkg::CNT_W'(lad_pkg::QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        den_reg <= den_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

@@ rtl/core/lad_datapath.sv @@
module lad_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  lad_pkg::cmd_t       cmd,
    output lad_pkg::status_t    status,
    input  lad_pkg::cfg_t       cfg,
    input  lad_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output lad_pkg::out_word_t  out_data
);

    localparam int unsigned W = lad_pkg::FIELD_W;

    lad_pkg::in_word_t   in_reg;
    logic                letter_reg, letter_next;
    logic                changed_reg, changed_next;
    logic                cls_en_reg, cls_en_next;
    logic [1:0]          class_reg, class_next;
    logic [W-1:0]        hw_reg, hw_next;
    logic [W-1:0]        hh_reg, hh_next;
    logic [W-1:0]        ml_reg, ml_next;
    logic [W-1:0]        mr_reg, mr_next;
    logic [W-1:0]        mt_reg, mt_next;
    logic [W-1:0]        mb_reg, mb_next;
    logic                out_valid_reg, out_valid_next;
    lad_pkg::out_word_t  out_reg, out_next;

    logic                res_lost;
    logic                lr_none, tb_none, lr_center, tb_center;
    logic                letter, pillar;
    logic [W-1:0]        act_w, act_h;
    logic                need_div, div_start, div_busy, div_done;
    logic [lad_pkg::QUOT_W-1:0] quot;
    logic [1:0]          cls;
    logic                cls_update;

    function automatic logic near(
        input logic [W-1:0]                a,
        input logic [W-1:0]                b,
        input logic [lad_pkg::CFG_W-1:0]   t
    );
        logic [W:0] ax, bx, tx;
        ax = {1'b0, a};
        bx = {1'b0, b};
        tx = (W+1)'(t);
        return (ax + tx >= bx) && (ax <= bx + tx);
    endfunction

    function automatic logic ratio_hit(
        input logic [lad_pkg::QUOT_W-1:0]  r,
        input logic [W-1:0]                c,
        input logic [lad_pkg::CFG_W-1:0]   t
    );
        logic [lad_pkg::QUOT_W:0] rx, cx, tx;
        rx = {1'b0, r};
        cx = (lad_pkg::QUOT_W+1)'(c);
        tx = (lad_pkg::QUOT_W+1)'(t);
        return (rx + tx > cx) && (rx < cx + tx);
    endfunction

    lad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({act_w, 8'd0}),
        .divisor  (act_h),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // Evaluation of the captured word against the held state.
    always_comb
    begin
        res_lost = !near(in_reg.total_width, hw_reg, cfg.res_tolerance) ||
                   !near(in_reg.total_height, hh_reg, cfg.res_tolerance) ||
                   (in_reg.left_bar < ml_reg) || (in_reg.right_bar < mr_reg) ||
                   (in_reg.top_bar < mt_reg) || (in_reg.bottom_bar < mb_reg);
        lr_none   = ({1'b0, in_reg.left_bar} + {1'b0, in_reg.right_bar}) <=
                    (W+1)'(cfg.fullscreen_limit);
        tb_none   = ({1'b0, in_reg.top_bar} + {1'b0, in_reg.bottom_bar}) <=
                    (W+1)'(cfg.fullscreen_limit);
        lr_center = near(in_reg.left_bar, in_reg.right_bar, cfg.centered_tolerance);
        tb_center = near(in_reg.top_bar, in_reg.bottom_bar, cfg.centered_tolerance);
        letter    = lr_none && tb_center;
        pillar    = !letter && tb_none && lr_center;
        act_w     = in_reg.total_width - in_reg.left_bar - in_reg.right_bar;
        act_h     = in_reg.total_height - in_reg.top_bar - in_reg.bottom_bar;
        need_div  = (letter || pillar) && (act_h != '0);
        div_start = cmd.eval && need_div;
    end

    // Class match; the first ratio that hits wins.
    always_comb
    begin
        if (!cls_en_reg)
            cls = lad_pkg::NO_CLASS;
        else if (ratio_hit(quot, lad_pkg::RATIO_CLASS0, cfg.ratio_tolerance))
            cls = lad_pkg::CLASS_WIDE;
        else if (ratio_hit(quot, lad_pkg::RATIO_CLASS1, cfg.ratio_tolerance))
            cls = lad_pkg::CLASS_SCOPE;
        else if (ratio_hit(quot, lad_pkg::RATIO_CLASS2, cfg.ratio_tolerance))
            cls = lad_pkg::CLASS_NARROW;
        else
            cls = lad_pkg::NO_CLASS;
        cls_update = (cls != lad_pkg::NO_CLASS) && (cls != class_reg);
    end

    always_comb
    begin
        letter_next    = letter_reg;
        changed_next   = changed_reg;
        cls_en_next    = cls_en_reg;
        class_next     = class_reg;
        hw_next        = hw_reg;
        hh_next        = hh_reg;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        mt_next        = mt_reg;
        mb_next        = mb_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.eval)
        begin
            letter_next  = letter;
            cls_en_next  = need_div;
            changed_next = res_lost;
            if (res_lost)
            begin
                class_next = lad_pkg::CLASS_WIDE;
                hw_next    = in_reg.total_width;
                hh_next    = in_reg.total_height;
                ml_next    = '0;
                mr_next    = '0;
                mt_next    = '0;
                mb_next    = '0;
            end
        end

        if (cmd.fin)
        begin
            if (cls_update)
            begin
                class_next = cls;
                if (letter_reg)
                begin
                    ml_next = '0;
                    mr_next = '0;
                    mt_next = lad_pkg::sub_sat(in_reg.top_bar, cfg.bar_guard);
                    mb_next = lad_pkg::sub_sat(in_reg.bottom_bar, cfg.bar_guard);
                end
                else
                begin
                    ml_next = lad_pkg::sub_sat(in_reg.left_bar, cfg.bar_guard);
                    mr_next = lad_pkg::sub_sat(in_reg.right_bar, cfg.bar_guard);
                    mt_next = '0;
                    mb_next = '0;
                end
            end
            out_next.format_changed = changed_reg || cls_update;
            out_next.locked_width   = hw_reg;
            out_next.locked_height  = hh_reg;
            out_next.aspect_class   = class_next;
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg     <= lad_pkg::CLASS_WIDE;
            hw_reg        <= lad_pkg::HELD_SIZE_RESET;
            hh_reg        <= lad_pkg::HELD_SIZE_RESET;
            ml_reg        <= '0;
            mr_reg        <= '0;
            mt_reg        <= '0;
            mb_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            class_reg     <= class_next;
            hw_reg        <= hw_next;
            hh_reg        <= hh_next;
            ml_reg        <= ml_next;
            mr_reg        <= mr_next;
            mt_reg        <= mt_next;
            mb_reg        <= mb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            in_reg <= in_data;
        letter_reg  <= letter_next;
        changed_reg <= changed_next;
        cls_en_reg  <= cls_en_next;
        out_reg     <= out_next;
    end

    assign status.need_div = need_div;
    assign status.div_done = div_done;
    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> $past(div_busy) && !div_busy)
        else $error("divider done without a run");
    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.aspect_class != lad_pkg::NO_CLASS))
        else $error("no-match code reached the output");
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> out_valid)
        else $error("finished word not presented");
`endif

endmodule

@@ rtl/core/lad_ctrl.sv @@
module lad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  lad_pkg::status_t  status,
    output lad_pkg::cmd_t     cmd
);

    lad_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lad_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            lad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lad_pkg::ST_EVAL;
                end
            end
            lad_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.need_div ? lad_pkg::ST_DIV : lad_pkg::ST_FIN;
            end
            lad_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = lad_pkg::ST_FIN;
            end
            lad_pkg::ST_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = lad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/letterbox_aspect_detector.sv @@
// Letterbox and pillarbox aspect detector.
// One input word per video frame carries the measured frame size and the
// blank bars on each side; each word yields exactly one output word with a
// change flag, the locked width and height, and the aspect class.
// Both word channels use valid/ready; a word moves when both are high.
// The APB-style port holds five 8-bit registers at byte addresses 0..16;
// pready is tied high and reads return the register value.
// Sequence: an accepted word is loaded and evaluated; when the frame shows a
// bar pattern and a nonzero active height, the active ratio is then computed
// by the 24-step serial divider forming active_width*256/active_height one
// quotient bit per cycle, and the result is then registered for the output.
// Words are handled one at a time; the input is taken again as soon as the
// result sits in the output register, even while the receiver has not yet
// taken it.
// If the receiver stalls, a second result waits inside until the output
// register empties, and no further input is taken meanwhile.
// Reset clears the held state to an unlocked 0xffff by 0xffff resolution,
// class 0 and zero bounds, and reloads the registers with their defaults.
module letterbox_aspect_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  lad_pkg::in_word_t             in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output lad_pkg::out_word_t            out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lad_pkg::ADDR_W-1:0]    paddr,
    input  logic [lad_pkg::DATA_W-1:0]    pwdata,
    output logic [lad_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    lad_pkg::cfg_t     cfg_reg, cfg_next;
    lad_pkg::cmd_t     cmd;
    lad_pkg::status_t  status;
    logic [2:0]        reg_idx;
    logic              wr_en;
    logic [lad_pkg::CFG_W-1:0] wr_val;
    logic [lad_pkg::CFG_W-1:0] rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;
    assign wr_val  = pwdata[lad_pkg::CFG_W-1:0];

    // Register writes; an address beyond the register list is ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (reg_idx)
                lad_pkg::REG_RES_TOL:    cfg_next.res_tolerance      = wr_val;
                lad_pkg::REG_BAR_GUARD:  cfg_next.bar_guard          = wr_val;
                lad_pkg::REG_FULL_LIMIT: cfg_next.fullscreen_limit   = wr_val;
                lad_pkg::REG_CENTER_TOL: cfg_next.centered_tolerance = wr_val;
                lad_pkg::REG_RATIO_TOL:  cfg_next.ratio_tolerance    = wr_val;
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    // Register read-back, valid during the access cycle.
    always_comb
    begin
        case (reg_idx)
            lad_pkg::REG_RES_TOL:    rd_val = cfg_reg.res_tolerance;
            lad_pkg::REG_BAR_GUARD:  rd_val = cfg_reg.bar_guard;
            lad_pkg::REG_FULL_LIMIT: rd_val = cfg_reg.fullscreen_limit;
            lad_pkg::REG_CENTER_TOL: rd_val = cfg_reg.centered_tolerance;
            lad_pkg::REG_RATIO_TOL:  rd_val = cfg_reg.ratio_tolerance;
            default:                 rd_val = '0;
        endcase
        prdata = lad_pkg::DATA_W'(rd_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.res_tolerance      <= lad_pkg::RES_TOL_RESET;
            cfg_reg.bar_guard          <= lad_pkg::BAR_GUARD_RESET;
            cfg_reg.fullscreen_limit   <= lad_pkg::FULL_LIMIT_RESET;
            cfg_reg.centered_tolerance <= lad_pkg::CENTER_TOL_RESET;
            cfg_reg.ratio_tolerance    <= lad_pkg::RATIO_TOL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // The controller sequences each word; the datapath holds the detection state.
    lad_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lad_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
